[design/i2a_pkg.sv]
// Shared types, constants and the digit-to-character function for the
// integer-to-ASCII converter. No dependencies.
`timescale 1ns / 1ps

package i2a_pkg;

  // Width of the word to convert and depth of the digit store.
  localparam int VALUE_WIDTH = 32;
  localparam int STORE_DEPTH = VALUE_WIDTH;
  localparam int RADIX_W     = 6;
  localparam int CHAR_W      = 7;
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // Divider: quotient bits resolved per cycle and divider steps per digit.
  localparam int DIV_BITS_PER_STEP = 8;
  localparam int DIV_STEPS         = VALUE_WIDTH / DIV_BITS_PER_STEP;
  localparam int DIV_CNT_W         = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);
  localparam logic [RADIX_W-1:0] RADIX_DEC = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] DIGIT_MAX_DEC = RADIX_W'(9);

  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'h61;
  localparam logic [CHAR_W-1:0] CHAR_MINUS   = 7'h2D;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic [RADIX_W-1:0]     radix;
  } in_beat_t;

  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic              last;
  } out_beat_t;

  // Divider handshake with the sequencer. The divisor is taken in only with
  // the first digit of a word and kept for the rest of it.
  typedef struct packed {
    logic start;
    logic load_divisor;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // Digit values above nine map to lower-case letters.
  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] dc;
    dc = CHAR_W'(d);
    if (d > DIGIT_MAX_DEC) begin
      return CHAR_LOWER_A + dc - CHAR_W'(RADIX_DEC);
    end
    return CHAR_ZERO + dc;
  endfunction

endpackage

[design/i2a_div_unit.sv]
// Iterative divider: divides the magnitude by the radix, a fixed number of
// quotient bits per cycle. Depends on i2a_pkg.
`timescale 1ns / 1ps

module i2a_div_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  i2a_pkg::div_ctrl_t                  ctrl,
  input  logic [i2a_pkg::VALUE_WIDTH-1:0]     dividend,
  input  logic [i2a_pkg::RADIX_W-1:0]         divisor,
  output i2a_pkg::div_status_t                status,
  output logic [i2a_pkg::VALUE_WIDTH-1:0]     quotient,
  output logic [i2a_pkg::RADIX_W-1:0]         remainder
);

  logic                               busy_r, busy_nxt;
  logic                               done_r, done_nxt;
  logic [i2a_pkg::DIV_CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [i2a_pkg::VALUE_WIDTH-1:0]    quo_r, quo_nxt;
  logic [i2a_pkg::RADIX_W-1:0]        rem_r, rem_nxt;
  logic [i2a_pkg::RADIX_W-1:0]        divisor_r, divisor_nxt;
  logic [i2a_pkg::VALUE_WIDTH-1:0]    quo_step;
  logic [i2a_pkg::RADIX_W-1:0]        rem_step;

  // Restoring division over a group of bits. The partial remainder stays
  // below the divisor, so the trial value needs one extra bit.
  always_comb begin
    logic [i2a_pkg::RADIX_W:0] trial;
    logic [i2a_pkg::RADIX_W:0] diff;
    rem_step = rem_r;
    quo_step = quo_r;
    for (int i = 0; i < i2a_pkg::DIV_BITS_PER_STEP; i++) begin
      trial    = {rem_step, quo_step[i2a_pkg::VALUE_WIDTH-1]};
      quo_step = {quo_step[i2a_pkg::VALUE_WIDTH-2:0], 1'b0};
      diff     = trial - {1'b0, divisor_r};
      if (trial >= {1'b0, divisor_r}) begin
        rem_step    = diff[i2a_pkg::RADIX_W-1:0];
        quo_step[0] = 1'b1;
      end else begin
        rem_step = trial[i2a_pkg::RADIX_W-1:0];
      end
    end
  end

  always_comb begin
    busy_nxt    = busy_r;
    done_nxt    = 1'b0;
    cnt_nxt     = cnt_r;
    quo_nxt     = quo_r;
    rem_nxt     = rem_r;
    divisor_nxt = divisor_r;
    if (ctrl.start) begin
      busy_nxt    = 1'b1;
      cnt_nxt     = '0;
      quo_nxt     = dividend;
      rem_nxt     = '0;
      if (ctrl.load_divisor) begin
        divisor_nxt = divisor;
      end
    end else if (busy_r) begin
      quo_nxt = quo_step;
      rem_nxt = rem_step;
      cnt_nxt = cnt_r + i2a_pkg::DIV_CNT_W'(1);
      if (cnt_r == i2a_pkg::DIV_CNT_W'(i2a_pkg::DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r     <= quo_nxt;
    rem_r     <= rem_nxt;
    divisor_r <= divisor_nxt;
  end

  assign status.busy = busy_r;
  assign status.done = done_r;
  assign quotient    = quo_r;
  assign remainder   = rem_r;

endmodule

[design/i2a_digit_buf.sv]
// Digit store: one write port and one registered read port.
// Depends on i2a_pkg.
`timescale 1ns / 1ps

module i2a_digit_buf (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [i2a_pkg::ADDR_W-1:0]     wr_addr,
  input  logic [i2a_pkg::RADIX_W-1:0]    wr_data,
  input  logic                           rd_en,
  input  logic [i2a_pkg::ADDR_W-1:0]     rd_addr,
  output logic [i2a_pkg::RADIX_W-1:0]    rd_data
);

  logic [i2a_pkg::RADIX_W-1:0] mem [i2a_pkg::STORE_DEPTH];
  logic [i2a_pkg::RADIX_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[design/integer_to_ascii_radix.sv]
// Integer to ASCII converter, radix 2 to 36. Top level; uses i2a_pkg,
// i2a_div_unit and i2a_digit_buf.
// Each digit is a remainder of repeated division by the radix; digits are stored and
// sent most significant first, after any leading minus. Zero skips the divider.
// A new word is accepted only once the last character of the previous one has entered
// the output register. Synchronous active-low reset clears the sequencer and the
// output valid; the digit store is not cleared.
`timescale 1ns / 1ps

module integer_to_ascii_radix (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  i2a_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output i2a_pkg::out_beat_t out_data
);

  // Sequencer states: wait for a word, divide, emit the sign, then read and
  // emit digits from the most significant one down.
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_SIGN = 5'b00100,
    ST_READ = 5'b01000,
    ST_LOAD = 5'b10000
  } state_t;

  state_t                            state_r, state_nxt;
  logic [i2a_pkg::CNT_W-1:0]         count_r, count_nxt;
  logic [i2a_pkg::ADDR_W-1:0]        idx_r, idx_nxt;
  logic                              minus_r, minus_nxt;
  logic                              out_valid_r, out_valid_nxt;
  i2a_pkg::out_beat_t                out_data_r, out_data_nxt;

  logic                              in_fire;
  logic                              out_free;
  logic [i2a_pkg::RADIX_W-1:0]       radix_sat;
  logic                              is_neg;
  logic [i2a_pkg::VALUE_WIDTH-1:0]   magnitude;

  i2a_pkg::div_ctrl_t                div_ctrl;
  i2a_pkg::div_status_t              div_status;
  logic [i2a_pkg::VALUE_WIDTH-1:0]   div_dividend;
  logic [i2a_pkg::VALUE_WIDTH-1:0]   div_quotient;
  logic [i2a_pkg::RADIX_W-1:0]       div_remainder;

  logic                              buf_wr_en;
  logic [i2a_pkg::ADDR_W-1:0]        buf_wr_addr;
  logic [i2a_pkg::RADIX_W-1:0]       buf_wr_data;
  logic                              buf_rd_en;
  logic [i2a_pkg::RADIX_W-1:0]       buf_rd_data;

  assign in_stall = (state_r != ST_IDLE);
  assign in_fire  = in_valid && !in_stall;
  // The output register can take a new character when it is empty or its
  // current beat is leaving in this cycle.
  assign out_free = !out_valid_r || !out_stall;

  // Out-of-range radix codes saturate to the nearest legal radix.
  always_comb begin
    radix_sat = in_data.radix;
    if (in_data.radix < i2a_pkg::RADIX_MIN) begin
      radix_sat = i2a_pkg::RADIX_MIN;
    end else if (in_data.radix > i2a_pkg::RADIX_MAX) begin
      radix_sat = i2a_pkg::RADIX_MAX;
    end
  end

  // Only decimal reads the word as signed. Negating in the word width gives
  // the true magnitude of the most negative value as an unsigned number.
  assign is_neg    = (radix_sat == i2a_pkg::RADIX_DEC) &&
                     in_data.value[i2a_pkg::VALUE_WIDTH-1];
  assign magnitude = is_neg ? (~in_data.value + i2a_pkg::VALUE_WIDTH'(1)) : in_data.value;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    minus_nxt     = minus_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    div_ctrl      = '0;
    div_dividend  = div_quotient;
    buf_wr_en     = 1'b0;
    buf_wr_addr   = count_r[i2a_pkg::ADDR_W-1:0];
    buf_wr_data   = div_remainder;
    buf_rd_en     = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          minus_nxt = is_neg;
          if (magnitude == '0) begin
            // Zero is the single digit '0'.
            buf_wr_en   = 1'b1;
            buf_wr_addr = '0;
            buf_wr_data = '0;
            count_nxt   = i2a_pkg::CNT_W'(1);
            state_nxt   = ST_SIGN;
          end else begin
            div_ctrl.start        = 1'b1;
            div_ctrl.load_divisor = 1'b1;
            div_dividend          = magnitude;
            count_nxt             = '0;
            state_nxt             = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_status.done) begin
          // Store this digit and keep dividing while anything is left.
          buf_wr_en = 1'b1;
          count_nxt = count_r + i2a_pkg::CNT_W'(1);
          if ((div_quotient == '0) ||
              (count_nxt == i2a_pkg::CNT_W'(i2a_pkg::STORE_DEPTH))) begin
            state_nxt = ST_SIGN;
          end else begin
            div_ctrl.start = 1'b1;
          end
        end
      end
      ST_SIGN: begin
        idx_nxt = i2a_pkg::ADDR_W'(count_r - i2a_pkg::CNT_W'(1));
        if (!minus_r) begin
          state_nxt = ST_READ;
        end else if (out_free) begin
          out_data_nxt.out_char = i2a_pkg::CHAR_MINUS;
          out_data_nxt.last     = 1'b0;
          out_valid_nxt         = 1'b1;
          minus_nxt             = 1'b0;
          state_nxt             = ST_READ;
        end
      end
      ST_READ: begin
        buf_rd_en = 1'b1;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (out_free) begin
          out_data_nxt.out_char = i2a_pkg::digit_to_char(buf_rd_data);
          out_data_nxt.last     = (idx_r == '0);
          out_valid_nxt         = 1'b1;
          if (idx_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_r - i2a_pkg::ADDR_W'(1);
            state_nxt = ST_READ;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      minus_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      minus_r     <= minus_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  // The radix is taken from the input beat at acceptance only; the divider
  // keeps its own copy for the whole conversion.
  i2a_div_unit u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (div_ctrl),
    .dividend  (div_dividend),
    .divisor   (radix_sat),
    .status    (div_status),
    .quotient  (div_quotient),
    .remainder (div_remainder)
  );

  i2a_digit_buf u_buf (
    .clk     (clk),
    .wr_en   (buf_wr_en),
    .wr_addr (buf_wr_addr),
    .wr_data (buf_wr_data),
    .rd_en   (buf_rd_en),
    .rd_addr (idx_r),
    .rd_data (buf_rd_data)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The divider only finishes while the sequencer waits for it.
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_status.done |-> (state_r == ST_DIV))
    else $error("divider finished outside the divide state");

  // The digit count never passes the store depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= i2a_pkg::CNT_W'(i2a_pkg::STORE_DEPTH))
    else $error("digit count beyond store depth");

  // An accepted word blocks the input in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> in_stall)
    else $error("input not stalled after acceptance");

  // A minus sign is never the final character of a conversion.
  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.out_char == i2a_pkg::CHAR_MINUS)) |-> !out_data_r.last)
    else $error("minus sign flagged as last character");

endmodule

[tb/integer_to_ascii_radix_checker.sv]
// Checker for the integer-to-ASCII converter: predicts the character text of
// every accepted word and compares each output beat with it. Uses i2a_pkg.
`timescale 1ns / 1ps

module integer_to_ascii_radix_checker
  import i2a_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_beat_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_beat_t out_data,
  output int        fail_count,
  output int        pending_beats,
  output int        chars_checked
);

  out_beat_t expected_chars[$];
  int        errors  = 0;
  int        checked = 0;

  initial begin
    fail_count    = 0;
    pending_beats = 0;
    chars_checked = 0;
  end

  // Work out the text of one word and append it to the expected characters.
  task automatic predict_text(input in_beat_t word);
    logic [VALUE_WIDTH-1:0] mag;
    logic [RADIX_W-1:0]     base;
    logic [RADIX_W-1:0]     digits[STORE_DEPTH];
    logic                   negative;
    int                     count;
    base = word.radix;
    if (base < RADIX_MIN) begin
      base = RADIX_MIN;
    end
    if (base > RADIX_MAX) begin
      base = RADIX_MAX;
    end
    negative = (base == RADIX_DEC) && word.value[VALUE_WIDTH-1];
    mag      = negative ? -word.value : word.value;
    count    = 0;
    if (mag == '0) begin
      digits[0] = '0;
      count     = 1;
    end
    while (mag != '0) begin
      digits[count] = RADIX_W'(mag % base);
      count++;
      mag = mag / base;
    end
    if (negative) begin
      expected_chars.push_back('{out_char: CHAR_MINUS, last: 1'b0});
    end
    for (int i = count - 1; i >= 0; i--) begin
      expected_chars.push_back('{
        out_char: (digits[i] > 9) ? CHAR_LOWER_A + CHAR_W'(digits[i] - 10)
                                  : CHAR_ZERO + CHAR_W'(digits[i]),
        last:     (i == 0)});
    end
  endtask

  task automatic report(input string what, input logic [CHAR_W-1:0] want,
                        input logic [CHAR_W-1:0] got);
    errors++;
    $display("%0t: %s mismatch, expected 'h%02h got 'h%02h", $time, what, want, got);
  endtask

  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_text(in_data);
      end
      if (out_valid && !out_stall) begin
        checked++;
        if (expected_chars.size() == 0) begin
          report("unexpected beat, char", '0, out_data.out_char);
        end else begin
          want = expected_chars.pop_front();
          if (want.out_char != out_data.out_char) begin
            report("char", want.out_char, out_data.out_char);
          end
          if (want.last != out_data.last) begin
            report("last flag", CHAR_W'(want.last), CHAR_W'(out_data.last));
          end
        end
      end
    end
    fail_count    <= errors;
    pending_beats <= expected_chars.size();
    chars_checked <= checked;
  end

endmodule

[tb/integer_to_ascii_radix_test.sv]
// Top of the integer-to-ASCII converter testbench: clock, reset, word stimulus,
// output back-pressure and the verdict. Uses i2a_pkg and the checker module.
`timescale 1ns / 1ps

module integer_to_ascii_radix_test;
  import i2a_pkg::*;

  // A long receiver hold-off, in cycles; longer than any single conversion so
  // the converter stays busy and keeps its input stalled.
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_WORDS = 130;
  // From this random word on, neither side idles any more.
  localparam int QUIET_FROM   = 105;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_beat_t out_data;

  int fail_count;
  int pending_beats;
  int chars_checked;

  // Handshake between the stimulus and the receiver process: each increment
  // of hold_req asks for one long hold-off of the output.
  int   hold_req = 0;
  logic quiet    = 1'b0;
  int   words_sent = 0;

  integer_to_ascii_radix i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  integer_to_ascii_radix_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .pending_beats (pending_beats),
    .chars_checked (chars_checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Safety net: the slowest correct run is well under a fifth of this.
  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Offer one word. An optional gap of idle cycles comes first; with no gap the
  // valid simply stays high from the previous beat, so it is never lowered and
  // raised in the same time step. Returns once the beat has been accepted.
  task automatic offer_word(input logic [VALUE_WIDTH-1:0] value,
                            input logic [RADIX_W-1:0] radix, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{value: value, radix: radix};
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  // Drop valid and wait until the checker holds no more expected characters.
  task automatic drain;
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_beats != 0);
  endtask

  function automatic int sender_gap();
    if (!quiet && $urandom_range(0, 5) == 0) begin
      return $urandom_range(1, 15);
    end
    return 0;
  endfunction

  // Random words lean towards the interesting shapes: small magnitudes, small
  // negatives, the word extremes and words of random length.
  function automatic logic [VALUE_WIDTH-1:0] random_value();
    case ($urandom_range(0, 5))
      0:       return VALUE_WIDTH'($urandom_range(0, 1000));
      1:       return -VALUE_WIDTH'($urandom_range(1, 1000));
      2: begin
        case ($urandom_range(0, 3))
          0:       return '0;
          1:       return '1;
          2:       return {1'b1, {(VALUE_WIDTH-1){1'b0}}};
          default: return {1'b0, {(VALUE_WIDTH-1){1'b1}}};
        endcase
      end
      3:       return VALUE_WIDTH'($urandom) >> $urandom_range(0, VALUE_WIDTH - 1);
      default: return VALUE_WIDTH'($urandom);
    endcase
  endfunction

  // Mostly legal radices; decimal gets extra weight because of the sign path,
  // and the whole six-bit field is used now and then to hit the saturation.
  function automatic logic [RADIX_W-1:0] random_radix();
    case ($urandom_range(0, 9))
      0:       return RADIX_DEC;
      1:       return RADIX_W'($urandom_range(0, 63));
      default: return RADIX_W'($urandom_range(2, 36));
    endcase
  endfunction

  // Receiver: random stall bursts, a long hold-off whenever the stimulus asks for
  // one, and no stalls at all once the run turns quiet.
  initial begin
    int burst;
    int holds_served;
    burst        = 0;
    holds_served = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req > holds_served) begin
        holds_served++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else if (burst > 0) begin
        burst--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        burst = $urandom_range(1, 15) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Stimulus: reset, a directed set of words, the back-pressure phase and its drain, then
  // the random words, and finally the drain and the verdict.
  initial begin
    logic [VALUE_WIDTH-1:0] most_neg;
    most_neg = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Zero in several radices, and the single-digit edges of the alphabet.
    offer_word('0, RADIX_DEC, sender_gap());
    offer_word('0, RADIX_MIN, sender_gap());
    offer_word('0, RADIX_MAX, sender_gap());
    offer_word(VALUE_WIDTH'(9), RADIX_DEC, sender_gap());
    offer_word(VALUE_WIDTH'(10), RADIX_W'(11), sender_gap());
    offer_word(VALUE_WIDTH'(35), RADIX_MAX, sender_gap());
    offer_word(VALUE_WIDTH'(1), RADIX_MIN, sender_gap());
    // All ones: 32 binary digits, hex, base 3, base 36 and minus one in decimal.
    offer_word('1, RADIX_MIN, sender_gap());
    offer_word('1, RADIX_W'(16), sender_gap());
    offer_word('1, RADIX_W'(3), sender_gap());
    offer_word('1, RADIX_MAX, sender_gap());
    offer_word('1, RADIX_DEC, sender_gap());
    // The most negative word must print its true magnitude in decimal and be
    // read as unsigned elsewhere; the most positive one has no sign.
    offer_word(most_neg, RADIX_DEC, sender_gap());
    offer_word(most_neg, RADIX_W'(16), sender_gap());
    offer_word(~most_neg, RADIX_DEC, sender_gap());
    offer_word(VALUE_WIDTH'(12345), RADIX_DEC, sender_gap());
    offer_word(-VALUE_WIDTH'(12345), RADIX_DEC, sender_gap());
    offer_word(-VALUE_WIDTH'(10), RADIX_DEC, sender_gap());
    offer_word(VALUE_WIDTH'(32'hDEADBEEF), RADIX_W'(16), sender_gap());
    offer_word(VALUE_WIDTH'(32'o1234567), RADIX_W'(8), sender_gap());
    // Out-of-range radices saturate to 2 and to 36.
    offer_word(VALUE_WIDTH'(1000), RADIX_W'(0), sender_gap());
    offer_word(VALUE_WIDTH'(1000), RADIX_W'(1), sender_gap());
    offer_word(VALUE_WIDTH'(123456789), RADIX_W'(37), sender_gap());
    offer_word(-VALUE_WIDTH'(5), RADIX_W'(63), sender_gap());

    // The receiver holds off for a long stretch while words keep coming, so
    // the converter backs up and its input stall has to hold the sender.
    hold_req++;
    for (int i = 0; i < 5; i++) begin
      offer_word(random_value(), random_radix(), 0);
    end
    // Then the sender stops until every character has come out.
    drain();

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == RANDOM_WORDS / 2) begin
        drain();
      end
      if (i == QUIET_FROM) begin
        quiet = 1'b1;
      end
      offer_word(random_value(), random_radix(), sender_gap());
    end

    drain();
    // Room for a stray beat after the last expected one.
    repeat (300) @(posedge clk);
    $display("Converted %0d words in radices 0 to 63, with zero, sign, saturation",
             words_sent);
    $display("and word-extreme cases under back-pressure; %0d characters checked.",
             chars_checked);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
